FILE: sv/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and codes of the slot pool allocator: request kinds, result
// status codes and the per-field write enables of the two state tables.
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

  // Fixed field widths of the stream payload
  localparam int unsigned ID_W     = 10;
  localparam int unsigned STATUS_W = 2;

  // Request kinds (travel on the slave tuser)
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status (travels on the master tuser)
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // Field write enables of the id table (indexed by slot id)
  typedef struct packed {
    logic live;
    logic pos;
  } id_wen_t;

  // Field write enables of the list table (indexed by stack / list position)
  typedef struct packed {
    logic free_id;
    logic active_id;
  } list_wen_t;

endpackage : spa_pkg

`default_nettype wire

FILE: sv/slot_pool_allocator_unit.sv
// A request is accepted in S_ACCEPT and its table reads return in S_EXEC, where
//   its result is loaded once the result slot is free. Only one request is in
//   flight, set by the read and write-back of the two single-write-port state tables.
// A waiting result does not block acceptance of the next request.
// Reset: asynchronous, active low; afterwards a clearing pass over all SLOTS
//   entries initialises both tables, and no request is accepted until it ends.
// ----------------------------------------------------------------------------
// slot_pool_allocator_unit
// Sparse-set slot allocator: free stack, dense active list and per-slot
// live mark / list position, kept in two synchronous tables.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_pool_allocator_unit #(
  parameter int unsigned SLOTS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [9:0] slot_id, [15:10] zero
  input  wire logic        s_axis_tuser,   // [0] op
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [9:0] granted_id, [19:10] live_count,
                                           // [23:20] zero
  output logic [1:0]       m_axis_tuser    // [1:0] status
);
  import spa_pkg::*;

  localparam int unsigned IdW = $clog2(SLOTS);

  typedef enum logic [1:0] {
    S_INIT,     // clearing pass over both tables
    S_ACCEPT,   // waiting for a request; table reads issued on accept
    S_EXEC      // read data back: decide, write back, load result
  } state_e;

  state_e         state_q;
  logic [IdW-1:0] sweep_q;
  logic [IdW-1:0] free_total_q, active_total_q;
  logic [IdW-1:0] free_total_d, active_total_d;
  logic           req_op_q, req_in_range_q;

  logic           out_valid_q;
  logic [ID_W-1:0] out_granted_q, out_live_q;
  status_e        out_status_q;
  logic [ID_W-1:0] out_granted_d;
  status_e        out_status_d;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic            in_fire;
  logic            in_op;
  logic [ID_W-1:0] in_slot;
  logic            in_range;

  assign s_axis_tready = (state_q == S_ACCEPT);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_op         = s_axis_tuser;
  assign in_slot       = s_axis_tdata[ID_W-1:0];
  // id 0 is reserved; ids at or above SLOTS do not exist
  assign in_range      = (in_slot != '0) && (32'(in_slot) < 32'(SLOTS));

  // --------------------------------------------------------------------------
  // Tables
  // --------------------------------------------------------------------------
  id_wen_t        a_wen;
  logic [IdW-1:0] a_waddr, a_wpos;
  logic           a_wlive;
  logic           a_rd_live;
  logic [IdW-1:0] a_rd_pos;

  list_wen_t      b_wen;
  logic [IdW-1:0] b_waddr, b_wfree, b_wactive, b_raddr;
  logic [IdW-1:0] b_rd_free, b_rd_active;

  // allocate pops at the stack top, release fetches the last list entry
  assign b_raddr = (in_op == OP_ALLOC) ? (free_total_q - 1'b1) : (active_total_q - 1'b1);

  spa_id_table #(.Slots(SLOTS)) u_id_table (
    .clk_i     (clk_i),
    .wr_en_i   (a_wen),
    .wr_addr_i (a_waddr),
    .wr_live_i (a_wlive),
    .wr_pos_i  (a_wpos),
    .rd_en_i   (in_fire),
    .rd_addr_i (IdW'(in_slot)),
    .rd_live_o (a_rd_live),
    .rd_pos_o  (a_rd_pos)
  );

  spa_list_table #(.Slots(SLOTS)) u_list_table (
    .clk_i       (clk_i),
    .wr_en_i     (b_wen),
    .wr_addr_i   (b_waddr),
    .wr_free_i   (b_wfree),
    .wr_active_i (b_wactive),
    .rd_en_i     (in_fire),
    .rd_addr_i   (b_raddr),
    .rd_free_o   (b_rd_free),
    .rd_active_o (b_rd_active)
  );

  // --------------------------------------------------------------------------
  // Execute-cycle decision
  // --------------------------------------------------------------------------
  logic exec_go;     // result slot free, so the write-back may happen
  logic free_nz;
  logic rel_ok;

  assign exec_go = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);
  assign free_nz = (free_total_q != '0);
  assign rel_ok  = req_in_range_q && a_rd_live;

  always_comb begin
    free_total_d   = free_total_q;
    active_total_d = active_total_q;
    out_granted_d  = '0;
    out_status_d   = ST_DONE;
    if (req_op_q == OP_ALLOC) begin
      if (free_nz) begin
        free_total_d   = free_total_q - 1'b1;
        active_total_d = active_total_q + 1'b1;
        out_granted_d  = ID_W'(b_rd_free);
      end else begin
        out_status_d   = ST_EMPTY;
      end
    end else begin
      if (rel_ok) begin
        free_total_d   = free_total_q + 1'b1;
        active_total_d = active_total_q - 1'b1;
      end else begin
        out_status_d   = ST_INVALID;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Table write port steering
  //  - init: live mark cleared, free stack entry k := SLOTS-1-k
  //  - accept of a release: live mark cleared early (a no-op if not live) and
  //    the id pushed just above the stack top; that entry is dead until the
  //    count grows, so the early push is harmless for an invalid release
  //  - execute: allocate records id / position, release moves the last list
  //    entry into the hole
  // --------------------------------------------------------------------------
  always_comb begin
    a_wen     = '0;
    a_waddr   = '0;
    a_wlive   = 1'b0;
    a_wpos    = '0;
    b_wen     = '0;
    b_waddr   = '0;
    b_wfree   = '0;
    b_wactive = '0;
    unique case (state_q)
      S_INIT: begin
        a_wen       = '{live: 1'b1, pos: 1'b1};
        a_waddr     = sweep_q;
        b_wen       = '{free_id: 1'b1, active_id: 1'b1};
        b_waddr     = sweep_q;
        b_wfree     = IdW'(SLOTS - 1) - sweep_q;
      end
      S_ACCEPT: begin
        if (in_fire && (in_op == OP_RELEASE)) begin
          a_wen.live   = in_range;
          a_waddr      = IdW'(in_slot);
          b_wen.free_id = 1'b1;
          b_waddr      = free_total_q;
          b_wfree      = IdW'(in_slot);
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          if ((req_op_q == OP_ALLOC) && free_nz) begin
            a_wen           = '{live: 1'b1, pos: 1'b1};
            a_waddr         = b_rd_free;
            a_wlive         = 1'b1;
            a_wpos          = active_total_q;
            b_wen.active_id = 1'b1;
            b_waddr         = active_total_q;
            b_wactive       = b_rd_free;
          end else if ((req_op_q == OP_RELEASE) && rel_ok) begin
            a_wen.pos       = 1'b1;
            a_waddr         = b_rd_active;
            a_wpos          = a_rd_pos;
            b_wen.active_id = 1'b1;
            b_waddr         = a_rd_pos;
            b_wactive       = b_rd_active;
          end
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // State, counters and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_INIT;
      sweep_q        <= '0;
      free_total_q   <= IdW'(SLOTS - 1);
      active_total_q <= '0;
      req_op_q       <= OP_ALLOC;
      req_in_range_q <= 1'b0;
      out_valid_q    <= 1'b0;
      out_granted_q  <= '0;
      out_live_q     <= '0;
      out_status_q   <= ST_DONE;
    end else begin
      // a result taken while the next one is loaded keeps the valid high
      if (out_valid_q && m_axis_tready && !exec_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == IdW'(SLOTS - 1)) begin
            state_q <= S_ACCEPT;
          end
        end
        S_ACCEPT: begin
          if (in_fire) begin
            req_op_q       <= in_op;
            req_in_range_q <= in_range;
            state_q        <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            free_total_q   <= free_total_d;
            active_total_q <= active_total_d;
            out_valid_q    <= 1'b1;
            out_granted_q  <= out_granted_d;
            out_status_q   <= out_status_d;
            out_live_q     <= ID_W'(active_total_d);
            state_q        <= S_ACCEPT;
          end
        end
        default: state_q <= S_INIT;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_live_q, out_granted_q};
  assign m_axis_tuser  = out_status_q;

`ifndef NO_ASSERTIONS
  // every id other than 0 is either free or live
  a_count_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (IdW+1)'(free_total_q) + (IdW+1)'(active_total_q) == (IdW+1)'(SLOTS - 1))
    else $error("free and live counts do not add up");

  // the free stack only ever yields real ids
  a_pop_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) && (req_op_q == OP_ALLOC) && free_nz |-> (b_rd_free != '0))
    else $error("free stack popped id 0");

  // an accepted request is worked off before the next one is taken
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_EXEC) && !s_axis_tready)
    else $error("request accepted while another is in flight");

  // a granted allocate raises the live count by one
  a_alloc_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go && (req_op_q == OP_ALLOC) && free_nz
    |=> active_total_q == $past(active_total_q) + 1'b1)
    else $error("live count not raised by allocate");
`endif

endmodule : slot_pool_allocator_unit

`default_nettype wire

FILE: sv/spa_id_table.sv
// ----------------------------------------------------------------------------
// spa_id_table
// Per-slot table: live mark and position in the active list. One write
// port with per-field enables, one registered read port (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module spa_id_table #(
  parameter int unsigned Slots = 1024,
  localparam int unsigned IdW  = $clog2(Slots)
) (
  input  wire logic             clk_i,
  input  wire spa_pkg::id_wen_t wr_en_i,
  input  wire logic [IdW-1:0]   wr_addr_i,
  input  wire logic             wr_live_i,
  input  wire logic [IdW-1:0]   wr_pos_i,
  input  wire logic             rd_en_i,
  input  wire logic [IdW-1:0]   rd_addr_i,
  output logic                  rd_live_o,
  output logic [IdW-1:0]        rd_pos_o
);
  import spa_pkg::*;

  logic           live_mem [Slots];
  logic [IdW-1:0] pos_mem  [Slots];

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_live_o <= live_mem[rd_addr_i];
      rd_pos_o  <= pos_mem[rd_addr_i];
    end
    if (wr_en_i.live) begin
      live_mem[wr_addr_i] <= wr_live_i;
    end
    if (wr_en_i.pos) begin
      pos_mem[wr_addr_i] <= wr_pos_i;
    end
  end

endmodule : spa_id_table

`default_nettype wire

FILE: sv/spa_list_table.sv
// ----------------------------------------------------------------------------
// spa_list_table
// Positional table: free stack entry and active list entry share an index.
// One write port with per-field enables, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_list_table #(
  parameter int unsigned Slots = 1024,
  localparam int unsigned IdW  = $clog2(Slots)
) (
  input  wire logic               clk_i,
  input  wire spa_pkg::list_wen_t wr_en_i,
  input  wire logic [IdW-1:0]     wr_addr_i,
  input  wire logic [IdW-1:0]     wr_free_i,
  input  wire logic [IdW-1:0]     wr_active_i,
  input  wire logic               rd_en_i,
  input  wire logic [IdW-1:0]     rd_addr_i,
  output logic [IdW-1:0]          rd_free_o,
  output logic [IdW-1:0]          rd_active_o
);
  import spa_pkg::*;

  logic [IdW-1:0] free_mem   [Slots];
  logic [IdW-1:0] active_mem [Slots];

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_free_o   <= free_mem[rd_addr_i];
      rd_active_o <= active_mem[rd_addr_i];
    end
    if (wr_en_i.free_id) begin
      free_mem[wr_addr_i] <= wr_free_i;
    end
    if (wr_en_i.active_id) begin
      active_mem[wr_addr_i] <= wr_active_i;
    end
  end

endmodule : spa_list_table

`default_nettype wire

FILE: tb/sv/slot_pool_allocator_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_pool_allocator_unit_test
// Self-checking bench for the slot pool allocator. A short table of requests
// covers reset state, the reserved id, stale releases and slot reuse. Random
// traffic then fills the pool to exhaustion and drains it again. Each result
// is checked against its typed row's expectation or a behavioural copy of the
// pool that tracks the free stack, the dense active list and the per-slot live marks.
// ----------------------------------------------------------------------------

module slot_pool_allocator_unit_test;
  import spa_pkg::*;

  localparam int unsigned SLOTS        = 1024;
  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned ITEMS_TOTAL  = 1570;
  localparam int unsigned QUIET_TAIL   = 150;   // final requests with no idling
  localparam int unsigned HOLD_CYCLES  = 80;    // long receiver back-pressure
  localparam int unsigned DRAIN_CYCLES = 10;    // settle time after last result
  localparam int unsigned LIMIT_CYCLES = 200_000;

  // One predicted result transaction
  typedef struct packed {
    logic [ID_W-1:0] granted;
    status_e         status;
    logic [ID_W-1:0] live;
  } grant_t;

  // One row of the opening table; typed rows carry their own expectation
  typedef struct {
    logic            op;
    logic [ID_W-1:0] id;
    bit              typed;
    grant_t          want;
  } request_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;    // [9:0] slot_id, [15:10] zero
  logic        s_axis_tuser;    // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;    // [9:0] granted_id, [19:10] live_count, [23:20] zero
  logic [1:0]  m_axis_tuser;    // [1:0] status

  // Shadow copy of the pool
  bit              pool_live       [SLOTS];
  logic [ID_W-1:0] pool_free_stack [SLOTS];
  logic [ID_W-1:0] pool_active     [SLOTS];
  logic [ID_W-1:0] pool_pos        [SLOTS];
  int unsigned     pool_free_cnt;
  int unsigned     pool_live_cnt;

  grant_t       owed_grants[$];      // results still to arrive, oldest first
  request_row_t opening_rows[$];
  int unsigned  requests_sent;
  int unsigned  results_seen;
  int unsigned  mismatches;
  bit           quiet;               // no idling on either side
  bit           hold_request;        // asks the receiver for one long hold-off

  slot_pool_allocator_unit #(
    .SLOTS (SLOTS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Free stack holds SLOTS-1 down to 1, top of stack last, so id 1 goes first
  task automatic pool_reset();
    for (int unsigned k = 0; k < SLOTS; k++) begin
      pool_live[k]       = 1'b0;
      pool_free_stack[k] = (k + 1 < SLOTS) ? ID_W'(SLOTS - 1 - k) : '0;
      pool_active[k]     = '0;
      pool_pos[k]        = '0;
    end
    pool_free_cnt = SLOTS - 1;
    pool_live_cnt = 0;
  endtask

  // Applies one request to the shadow pool and returns the result it yields
  function automatic grant_t pool_apply(input logic op, input logic [ID_W-1:0] id);
    grant_t          r;
    logic [ID_W-1:0] hole;
    logic [ID_W-1:0] moved;
    r.granted = '0;
    r.status  = ST_DONE;
    if (op == OP_ALLOC) begin
      if (pool_free_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        pool_free_cnt--;
        r.granted                  = pool_free_stack[pool_free_cnt];
        pool_pos[r.granted]        = ID_W'(pool_live_cnt);
        pool_active[pool_live_cnt] = r.granted;
        pool_live_cnt++;
        pool_live[r.granted]       = 1'b1;
      end
    end else if (id == '0 || !pool_live[id]) begin
      // reserved id or not live; ids of SLOTS and up do not fit in ten bits
      r.status = ST_INVALID;
    end else begin
      // swap-remove: last list entry fills the hole
      hole                 = pool_pos[id];
      moved                = pool_active[pool_live_cnt - 1];
      pool_active[hole]    = moved;
      pool_pos[moved]      = hole;
      pool_live_cnt--;
      pool_live[id]        = 1'b0;
      pool_free_stack[pool_free_cnt] = id;
      pool_free_cnt++;
    end
    r.live = ID_W'(pool_live_cnt);
    return r;
  endfunction

  // Release target: mostly a live id, otherwise any id, with 0 now and then
  function automatic logic [ID_W-1:0] release_target(input int unsigned live_pct);
    if (pool_live_cnt != 0 && $urandom_range(0, 99) < live_pct)
      return pool_active[$urandom_range(0, pool_live_cnt - 1)];
    if ($urandom_range(0, 15) == 0)
      return '0;
    return ID_W'($urandom_range(0, SLOTS - 1));
  endfunction

  function automatic request_row_t row(input logic op, input logic [ID_W-1:0] id,
                                       input bit typed, input logic [ID_W-1:0] granted,
                                       input status_e status, input logic [ID_W-1:0] live);
    request_row_t r;
    r.op           = op;
    r.id           = id;
    r.typed        = typed;
    r.want.granted = granted;
    r.want.status  = status;
    r.want.live    = live;
    return r;
  endfunction

  // Offers one request and waits for its transaction. The valid set here
  // carries over into the next call, so it drops between items only when that call idles.
  task automatic offer_request(input logic op, input logic [ID_W-1:0] id,
                               input bit typed, input grant_t typed_want);
    grant_t want;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(16 - ID_W){1'b0}}, id};
    do @(posedge clk_i); while (!s_axis_tready);
    want = pool_apply(op, id);
    owed_grants.push_back(typed ? typed_want : want);
    requests_sent++;
  endtask

  task automatic offer_random(input int unsigned alloc_pct, input int unsigned live_pct);
    if ($urandom_range(0, 99) < alloc_pct)
      offer_request(OP_ALLOC, ID_W'($urandom_range(0, SLOTS - 1)), 1'b0, '0);
    else
      offer_request(OP_RELEASE, release_target(live_pct), 1'b0, '0);
  endtask

  // Result side: checks each transaction, then chooses the next tready.
  // Sampling straight after the edge sees the values the edge acted on.
  initial begin
    int unsigned stall_left;
    grant_t      want;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (owed_grants.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: nothing expected, got id %0d status %0d live %0d",
                     results_seen, m_axis_tdata[ID_W-1:0], m_axis_tuser,
                     m_axis_tdata[2*ID_W-1:ID_W]);
        end else begin
          want = owed_grants.pop_front();
          if (m_axis_tdata[ID_W-1:0] !== want.granted ||
              m_axis_tuser !== want.status ||
              m_axis_tdata[2*ID_W-1:ID_W] !== want.live) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected id %0d status %0d live %0d, got id %0d status %0d live %0d",
                       results_seen, want.granted, want.status, want.live,
                       m_axis_tdata[ID_W-1:0], m_axis_tuser,
                       m_axis_tdata[2*ID_W-1:ID_W]);
          end
        end
      end
      // one assignment to tready per edge
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        // long hold-off: the block fills up and must stall its input
        hold_request  = 1'b0;
        stall_left    = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left    = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("slot_pool_allocator_unit_test failed");
    $finish;
  end

  initial begin
    int unsigned drain_n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ALLOC;
    requests_sent = 0;
    results_seen  = 0;
    mismatches    = 0;
    quiet         = 1'b0;
    hold_request  = 1'b0;
    pool_reset();

    // Opening table. Typed rows: reset state, reserved id, top id, stale ids.
    // Swap-removes and reuse of released ids go to the shadow pool.
    opening_rows.push_back(row(OP_RELEASE, '0,         1, '0, ST_INVALID, 10'd0));
    opening_rows.push_back(row(OP_RELEASE, 10'd1023,   1, '0, ST_INVALID, 10'd0));
    opening_rows.push_back(row(OP_RELEASE, 10'd1,      1, '0, ST_INVALID, 10'd0));
    opening_rows.push_back(row(OP_ALLOC,   10'd1023,   1, 10'd1, ST_DONE, 10'd1));
    opening_rows.push_back(row(OP_ALLOC,   '0,         1, 10'd2, ST_DONE, 10'd2));
    opening_rows.push_back(row(OP_ALLOC,   10'h2AA,    1, 10'd3, ST_DONE, 10'd3));
    opening_rows.push_back(row(OP_RELEASE, 10'd2,      0, '0, ST_DONE,    '0));  // middle
    opening_rows.push_back(row(OP_RELEASE, 10'd2,      1, '0, ST_INVALID, 10'd2));
    opening_rows.push_back(row(OP_RELEASE, 10'd3,      0, '0, ST_DONE,    '0));  // moved one
    opening_rows.push_back(row(OP_ALLOC,   10'h155,    0, '0, ST_DONE,    '0));  // reuse
    opening_rows.push_back(row(OP_RELEASE, '0,         1, '0, ST_INVALID, 10'd2));
    opening_rows.push_back(row(OP_RELEASE, 10'd1023,   1, '0, ST_INVALID, 10'd2));
    opening_rows.push_back(row(OP_RELEASE, 10'h2AA,    1, '0, ST_INVALID, 10'd2));
    opening_rows.push_back(row(OP_RELEASE, 10'h155,    1, '0, ST_INVALID, 10'd2));
    opening_rows.push_back(row(OP_RELEASE, 10'd1,      0, '0, ST_DONE,    '0));
    opening_rows.push_back(row(OP_RELEASE, 10'd3,      0, '0, ST_DONE,    '0));  // now empty
    opening_rows.push_back(row(OP_ALLOC,   '0,         0, '0, ST_DONE,    '0));
    opening_rows.push_back(row(OP_ALLOC,   '0,         0, '0, ST_DONE,    '0));
    opening_rows.push_back(row(OP_ALLOC,   '0,         0, '0, ST_DONE,    '0));
    opening_rows.push_back(row(OP_RELEASE, 10'd1,      0, '0, ST_DONE,    '0));
    opening_rows.push_back(row(OP_ALLOC,   10'd1023,   0, '0, ST_DONE,    '0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // tready stays low through the clearing pass; the handshake waits it out
    foreach (opening_rows[i])
      offer_request(opening_rows[i].op, opening_rows[i].id,
                    opening_rows[i].typed, opening_rows[i].want);

    // Mixed traffic around a small live set, one long receiver hold
    for (int i = 0; i < 250; i++) begin
      if (i == 60)
        hold_request = 1'b1;
      offer_random(55, 75);
    end

    // Fill until the free stack runs dry, then sit at the empty boundary
    while (pool_free_cnt != 0)
      offer_random(95, 90);
    hold_request = 1'b1;
    repeat (40)
      offer_random(60, 80);

    // Drain; the tail runs with both sides flat out
    drain_n = (requests_sent + QUIET_TAIL > ITEMS_TOTAL) ? QUIET_TAIL
                                                         : ITEMS_TOTAL - requests_sent;
    for (int unsigned i = 0; i < drain_n; i++) begin
      quiet = (drain_n - i <= QUIET_TAIL);
      offer_random(15, 90);
    end
    s_axis_tvalid <= 1'b0;

    while (owed_grants.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("slot_pool_allocator_unit_test passed");
    end else begin
      $display("slot_pool_allocator_unit_test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/spa_pkg.sv
sv/spa_id_table.sv
sv/spa_list_table.sv
sv/slot_pool_allocator_unit.sv
tb/sv/slot_pool_allocator_unit_test.sv
